### rtl/core/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants for the array list engine: request and result
// codes, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int ALE_DEPTH = 16;  // default list capacity
    localparam int ALE_DW    = 32;  // entry and value width
    localparam int ALE_POS_W = 5;   // request position width
    localparam int ALE_IDX_W = 4;   // result index width
    localparam int ALE_CNT_W = 5;   // result count width

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_LOCATE = 2'd2,
        ACT_SORTED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // where the walk pointer starts when a request is loaded
    typedef enum logic [1:0] {
        INIT_ZERO,
        INIT_CLAMP,
        INIT_NEXT
    } t_ptr_init;

    typedef struct packed {
        logic      load;
        t_ptr_init init;
        logic      set_status;
        t_status   status;
        logic      set_idx;
        logic      adv;
        logic      take;
        logic      wr;
        logic      wr_carry;
        logic      wr_prev;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic pos_bad;
        logic at_end;
        logic eq;
        logic lt;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// Request sequencer: decodes the action, steps the datapath walk over the
// list one entry per cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
module ale_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_action,
    input  ale_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output ale_pkg::t_cmd o_cmd
);
    import ale_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_LOC,
        M_SORT,
        M_RIP,
        M_DEL
    } t_mode;

    t_state  r_state, n_state;
    t_mode   r_mode, n_mode;
    t_action act;
    t_cmd    cmd;

    assign act = t_action'(i_action);

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_mode  = r_mode;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load       = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    cmd.init       = INIT_ZERO;
                    n_state        = S_RUN;
                    case (act)
                        ACT_INSERT: begin
                            if (i_stat.full) begin
                                cmd.status = ST_FULL;
                                n_state    = S_DONE;
                            end else begin
                                cmd.init = INIT_CLAMP;
                                n_mode   = M_RIP;
                            end
                        end
                        ACT_DELETE: begin
                            if (i_stat.pos_bad) begin
                                cmd.status = ST_BAD_POS;
                                n_state    = S_DONE;
                            end else begin
                                cmd.init = INIT_NEXT;
                                n_mode   = M_DEL;
                            end
                        end
                        ACT_LOCATE: begin
                            n_mode = M_LOC;
                        end
                        ACT_SORTED: begin
                            if (i_stat.full) begin
                                cmd.status = ST_FULL;
                                n_state    = S_DONE;
                            end else begin
                                n_mode = M_SORT;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                case (r_mode)
                    M_LOC: begin
                        if (i_stat.at_end) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NOT_FOUND;
                            n_state        = S_DONE;
                        end else if (i_stat.eq) begin
                            cmd.set_idx = 1'b1;
                            n_state     = S_DONE;
                        end else begin
                            cmd.adv = 1'b1;
                        end
                    end
                    M_SORT: begin
                        if (i_stat.at_end || !i_stat.lt) begin
                            // slot found: drop the value in and, unless at the list end, start rippling
                            cmd.set_idx  = 1'b1;
                            cmd.wr       = 1'b1;
                            cmd.wr_carry = 1'b1;
                            if (i_stat.at_end) begin
                                cmd.cnt_inc = 1'b1;
                                n_state     = S_DONE;
                            end else begin
                                cmd.adv  = 1'b1;
                                cmd.take = 1'b1;
                                n_mode   = M_RIP;
                            end
                        end else begin
                            cmd.adv = 1'b1;
                        end
                    end
                    M_RIP: begin
                        cmd.wr       = 1'b1;
                        cmd.wr_carry = 1'b1;
                        if (i_stat.at_end) begin
                            cmd.cnt_inc = 1'b1;
                            n_state     = S_DONE;
                        end else begin
                            cmd.adv  = 1'b1;
                            cmd.take = 1'b1;
                        end
                    end
                    M_DEL: begin
                        if (i_stat.at_end) begin
                            cmd.cnt_dec = 1'b1;
                            n_state     = S_DONE;
                        end else begin
                            cmd.wr      = 1'b1;
                            cmd.wr_prev = 1'b1;
                            cmd.adv     = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_LOC;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

endmodule

### rtl/core/ale_dpath.sv
// ----------------------------------------------------------------------------
// ale_dpath
// List storage and walk datapath: entry memory with registered read, walk
// pointer, ripple carry, entry count, compare flags and the result register.
// ----------------------------------------------------------------------------
module ale_dpath #(
    parameter int DEPTH = ale_pkg::ALE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ale_pkg::t_cmd                        i_cmd,
    input  logic signed [ale_pkg::ALE_DW-1:0]    i_value,
    input  logic [ale_pkg::ALE_POS_W-1:0]        i_position,
    input  logic                                 i_out_stall,
    output ale_pkg::t_stat                       o_stat,
    output logic                                 o_out_valid,
    output logic [1:0]                           o_status,
    output logic [ale_pkg::ALE_IDX_W-1:0]        o_index,
    output logic [ale_pkg::ALE_CNT_W-1:0]        o_count
);
    import ale_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > ALE_POS_W) ? CW : ALE_POS_W;

    logic signed [ALE_DW-1:0] mem [DEPTH];

    logic [CW-1:0]            r_ptr, n_ptr;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_idx;
    t_status                  r_status;
    logic signed [ALE_DW-1:0] r_val;
    logic signed [ALE_DW-1:0] r_carry;
    logic signed [ALE_DW-1:0] r_rdata;
    logic                     r_out_valid;
    logic [1:0]               r_o_status;
    logic [ALE_IDX_W-1:0]     r_o_index;
    logic [ALE_CNT_W-1:0]     r_o_count;

    logic [PW-1:0]            pos_ext, cnt_ext;
    logic [CW-1:0]            pos_clamp;
    logic [CW-1:0]            wr_ptr;
    logic signed [ALE_DW-1:0] wr_data;
    logic [31:0]              idx_wide, cnt_wide;
    logic                     out_free;

    assign pos_ext   = PW'(i_position);
    assign cnt_ext   = PW'(r_count);
    assign pos_clamp = (pos_ext > cnt_ext) ? r_count : CW'(pos_ext);

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.load) begin
            case (i_cmd.init)
                INIT_CLAMP: n_ptr = pos_clamp;
                INIT_NEXT:  n_ptr = CW'(pos_ext + PW'(1));
                default:    n_ptr = '0;
            endcase
        end else if (i_cmd.adv) begin
            n_ptr = r_ptr + CW'(1);
        end
    end

    assign wr_ptr  = i_cmd.wr_prev ? (r_ptr - CW'(1)) : r_ptr;
    assign wr_data = i_cmd.wr_carry ? r_carry : r_rdata;

    // read data always tracks the entry under the walk pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[wr_ptr[AW-1:0]] <= wr_data;
        end
        r_rdata <= mem[n_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_val   <= i_value;
            r_carry <= i_value;
            r_idx   <= pos_clamp;
        end else begin
            if (i_cmd.take) begin
                r_carry <= r_rdata;
            end
            if (i_cmd.set_idx) begin
                r_idx <= r_ptr;
            end
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_wide = 32'(r_idx);
    assign cnt_wide = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_index  <= (r_status == ST_OK) ? idx_wide[ALE_IDX_W-1:0] : '0;
            r_o_count  <= cnt_wide[ALE_CNT_W-1:0];
        end
    end

    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.pos_bad  = (pos_ext >= cnt_ext);
    assign o_stat.at_end   = (r_ptr == r_count);
    assign o_stat.eq       = (r_rdata == r_val);
    assign o_stat.lt       = (r_rdata < r_val);
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_index     = r_o_index;
    assign o_count     = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_wr_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> (r_ptr <= r_count))
        else $error("write beyond the list end");

    a_no_grow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (r_count != CW'(DEPTH)))
        else $error("count increment on a full list");

    a_out_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten while held");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.cnt_inc && !i_cmd.cnt_dec) |=> $stable(r_count))
        else $error("count changed without a command");

endmodule

### rtl/core/array_list_engine.sv
// ----------------------------------------------------------------------------
// array_list_engine
// Fixed-capacity ordered list of signed 32-bit values with insert, delete,
// locate and sorted insert requests, one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. A locate or sorted insert walks over
// the entries from index 0 up to the match or the list end, an insert at a
// position walks from that position to the end, and a delete from the
// position after it to the end. The entry memory moves one entry per cycle
// with one read and one write; rejected requests skip the walk. A finished
// result sits in an output register, so the next request is taken while the
// previous result waits to be collected.
// ----------------------------------------------------------------------------
module array_list_engine #(
    parameter int DEPTH = ale_pkg::ALE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_action,
    input  logic signed [ale_pkg::ALE_DW-1:0] i_value,
    input  logic [ale_pkg::ALE_POS_W-1:0]     i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [ale_pkg::ALE_IDX_W-1:0]     o_index,
    output logic [ale_pkg::ALE_CNT_W-1:0]     o_count
);
    import ale_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ale_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_position  (i_position),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_index     (o_index),
        .o_count     (o_count)
    );

endmodule
